[sv/i2cs_pkg.sv]
// Package for the I2C master transaction sequencer.
// Holds the phase, command and bus status codes and the sequencer state types.
// It has no dependencies.
package i2cs_pkg;

  localparam int COUNT_WIDTH = 16;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_WSTART = 3'd1,
    PH_WADDR  = 3'd2,
    PH_WFETCH = 3'd3,
    PH_WDATA  = 3'd4,
    PH_RSTART = 3'd5,
    PH_RADDR  = 3'd6,
    PH_RDATA  = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    REQ_TXN   = 2'd0,
    REQ_EVENT = 2'd1,
    REQ_WBYTE = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_SEND  = 3'd2,
    CMD_RACK  = 3'd3,
    CMD_RNACK = 3'd4,
    CMD_STOP  = 3'd5
  } cmd_t;

  // Bus engine status codes after masking.
  localparam logic [7:0] ST_MASK      = 8'hf8;
  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_REP_START = 8'h10;
  localparam logic [7:0] ST_WADDR_ACK = 8'h18;
  localparam logic [7:0] ST_WADDR_NAK = 8'h20;
  localparam logic [7:0] ST_WDATA_ACK = 8'h28;
  localparam logic [7:0] ST_WDATA_NAK = 8'h30;
  localparam logic [7:0] ST_RADDR_ACK = 8'h40;
  localparam logic [7:0] ST_RADDR_NAK = 8'h48;
  localparam logic [7:0] ST_RDATA_ACK = 8'h50;
  localparam logic [7:0] ST_RDATA_NAK = 8'h58;
  localparam logic [7:0] ADDR_WMASK   = 8'hfe;

  localparam logic [COUNT_WIDTH:0]   WL_ONE = {{COUNT_WIDTH{1'b0}}, 1'b1};
  localparam logic [COUNT_WIDTH-1:0] RL_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

  typedef struct packed {
    phase_t                 phase;
    logic [COUNT_WIDTH:0]   write_left;
    logic [COUNT_WIDTH-1:0] read_left;
    logic [7:0]             target_addr;
    logic                   wrote_flag;
  } seq_state_t;

  typedef struct packed {
    cmd_t       engine_cmd;
    logic [7:0] engine_tx_byte;
    logic       need_write_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       done_res;
    logic [7:0] done_status;
  } seq_result_t;

endpackage

[sv/i2cs_step.sv]
// Next-state and result logic of the I2C transaction sequencer for one beat.
// Purely combinational; uses the types and codes of i2cs_pkg.
module i2cs_step import i2cs_pkg::*; (
  input  seq_state_t  st,
  input  logic [1:0]  req_type,
  input  logic [7:0]  dev_addr,
  input  logic [15:0] prefix_count,
  input  logic [15:0] write_count,
  input  logic [15:0] read_count,
  input  logic [7:0]  write_byte,
  input  logic [7:0]  engine_status,
  input  logic [7:0]  engine_rx_byte,
  output seq_state_t  st_nxt,
  output seq_result_t res,
  output logic        res_hit
);

  logic [7:0]             s;
  logic [COUNT_WIDTH:0]   sum;
  logic [COUNT_WIDTH-1:0] rl_dec;
  logic [7:0]             ok_code;
  logic [7:0]             nak_code;

  assign s   = engine_status & ST_MASK;
  assign sum = {1'b0, prefix_count[COUNT_WIDTH-1:0]} + {1'b0, write_count[COUNT_WIDTH-1:0]};
  assign rl_dec = (st.read_left != '0) ? st.read_left - RL_ONE : st.read_left;
  assign ok_code  = (st.phase == PH_WADDR) ? ST_WADDR_ACK : ST_WDATA_ACK;
  assign nak_code = (st.phase == PH_WADDR) ? ST_WADDR_NAK : ST_WDATA_NAK;

  always_comb begin
    st_nxt  = st;
    res     = '0;
    res_hit = 1'b0;
    unique case (req_t'(req_type))
      REQ_TXN: begin
        if (st.phase == PH_IDLE) begin
          res_hit            = 1'b1;
          st_nxt.target_addr = dev_addr;
          st_nxt.write_left  = sum;
          st_nxt.read_left   = read_count[COUNT_WIDTH-1:0];
          st_nxt.wrote_flag  = (sum != '0);
          if (sum != '0) begin
            res.engine_cmd = CMD_START;
            st_nxt.phase   = PH_WSTART;
          end else if (read_count[COUNT_WIDTH-1:0] != '0) begin
            res.engine_cmd = CMD_START;
            st_nxt.phase   = PH_RSTART;
          end else begin
            // Nothing to move on the bus: report success without a STOP.
            res.done_res = 1'b1;
            st_nxt.phase = PH_IDLE;
          end
        end
      end
      REQ_WBYTE: begin
        if (st.phase == PH_WFETCH) begin
          res_hit            = 1'b1;
          res.engine_cmd     = CMD_SEND;
          res.engine_tx_byte = write_byte;
          if (st.write_left != '0) begin
            st_nxt.write_left = st.write_left - WL_ONE;
          end
          st_nxt.phase = PH_WDATA;
        end
      end
      REQ_EVENT: begin
        unique case (st.phase)
          PH_IDLE, PH_WFETCH: begin
          end
          PH_WSTART: begin
            res_hit = 1'b1;
            if (s != ST_START) begin
              res.done_res    = 1'b1;
              res.done_status = s;
              st_nxt.phase    = PH_IDLE;
            end else begin
              res.engine_cmd     = CMD_SEND;
              res.engine_tx_byte = st.target_addr & ADDR_WMASK;
              st_nxt.phase       = PH_WADDR;
            end
          end
          PH_WADDR, PH_WDATA: begin
            res_hit = 1'b1;
            if (s != ok_code) begin
              // A NAK from the device still releases the bus with a STOP.
              if (s == nak_code) begin
                res.engine_cmd = CMD_STOP;
              end
              res.done_res    = 1'b1;
              res.done_status = s;
              st_nxt.phase    = PH_IDLE;
            end else if (st.write_left != '0) begin
              res.need_write_byte = 1'b1;
              st_nxt.phase        = PH_WFETCH;
            end else if (st.read_left != '0) begin
              res.engine_cmd = CMD_START;
              st_nxt.phase   = PH_RSTART;
            end else begin
              res.engine_cmd = CMD_STOP;
              res.done_res   = 1'b1;
              st_nxt.phase   = PH_IDLE;
            end
          end
          PH_RSTART: begin
            res_hit = 1'b1;
            if (s != (st.wrote_flag ? ST_REP_START : ST_START)) begin
              res.done_res    = 1'b1;
              res.done_status = s;
              st_nxt.phase    = PH_IDLE;
            end else begin
              res.engine_cmd     = CMD_SEND;
              res.engine_tx_byte = st.target_addr | 8'h01;
              st_nxt.phase       = PH_RADDR;
            end
          end
          PH_RADDR: begin
            res_hit = 1'b1;
            if (s != ST_RADDR_ACK) begin
              if (s == ST_RADDR_NAK) begin
                res.engine_cmd = CMD_STOP;
              end
              res.done_res    = 1'b1;
              res.done_status = s;
              st_nxt.phase    = PH_IDLE;
            end else begin
              res.engine_cmd = (st.read_left > RL_ONE) ? CMD_RACK : CMD_RNACK;
              st_nxt.phase   = PH_RDATA;
            end
          end
          PH_RDATA: begin
            res_hit = 1'b1;
            if (s != ((st.read_left > RL_ONE) ? ST_RDATA_ACK : ST_RDATA_NAK)) begin
              res.done_res    = 1'b1;
              res.done_status = s;
              st_nxt.phase    = PH_IDLE;
            end else begin
              res.rx_valid     = 1'b1;
              res.rx_byte      = engine_rx_byte;
              st_nxt.read_left = rl_dec;
              if (rl_dec != '0) begin
                res.engine_cmd = (rl_dec > RL_ONE) ? CMD_RACK : CMD_RNACK;
                st_nxt.phase   = PH_RDATA;
              end else begin
                res.engine_cmd = CMD_STOP;
                res.done_res   = 1'b1;
                st_nxt.phase   = PH_IDLE;
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule

[sv/i2c_master_transaction_sequencer.sv]
// I2C master transaction sequencer, top level.
// Depends on i2cs_pkg and instantiates i2cs_step.
//
// Usage: the host sends beats on the in_ channel: a transaction request, an
// engine completion event with the raw status and received byte, or the next
// write byte after the block asked for it with out_need_write_byte. Each beat
// that fits the current phase produces exactly one result beat on the out_
// channel carrying the next engine command, any received byte and the done
// flag with its status. Beats that do not fit the phase are consumed without
// a result and leave the state alone.
// The result is captured in the output register by the edge that accepts its input
// beat. Throughput: one beat per cycle while the receiver does not stall, set by the
// single registered pass through the phase logic.
// Reset (rst_n low at a clock edge) returns the sequencer to idle, clears the
// counters and the address and drops out_valid; the result fields are not reset.
// When the receiver stalls, the output register holds its beat and in_ready
// drops; a new beat is taken in the same cycle the held one is taken.
module i2c_master_transaction_sequencer import i2cs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_dev_addr,
  input  logic [15:0] in_prefix_count,
  input  logic [15:0] in_write_count,
  input  logic [15:0] in_read_count,
  input  logic [7:0]  in_write_byte,
  input  logic [7:0]  in_engine_status,
  input  logic [7:0]  in_engine_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_engine_cmd,
  output logic [7:0]  out_engine_tx_byte,
  output logic        out_need_write_byte,
  output logic        out_rx_valid,
  output logic [7:0]  out_rx_byte,
  output logic        out_done_res,
  output logic [7:0]  out_done_status
);

  seq_state_t  state_r;
  seq_state_t  state_nxt;
  seq_result_t res_r;
  seq_result_t res_nxt;
  logic        res_hit;
  logic        out_valid_r;
  logic        accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  i2cs_step u_step (
    .st             (state_r),
    .req_type       (in_req_type),
    .dev_addr       (in_dev_addr),
    .prefix_count   (in_prefix_count),
    .write_count    (in_write_count),
    .read_count     (in_read_count),
    .write_byte     (in_write_byte),
    .engine_status  (in_engine_status),
    .engine_rx_byte (in_engine_rx_byte),
    .st_nxt         (state_nxt),
    .res            (res_nxt),
    .res_hit        (res_hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '{phase: PH_IDLE, default: '0};
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r <= state_nxt;
      end
      if (accept) begin
        out_valid_r <= res_hit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_hit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_engine_cmd      = res_r.engine_cmd;
  assign out_engine_tx_byte  = res_r.engine_tx_byte;
  assign out_need_write_byte = res_r.need_write_byte;
  assign out_rx_valid        = res_r.rx_valid;
  assign out_rx_byte         = res_r.rx_byte;
  assign out_done_res        = res_r.done_res;
  assign out_done_status     = res_r.done_status;

endmodule

[tb/i2c_master_transaction_sequencer_tb.sv]
// Testbench for the I2C master transaction sequencer: directed and random transactions.
// Checks every result beat against a cycle-free model of the phase logic.
// Depends on i2cs_pkg and i2c_master_transaction_sequencer.
`timescale 1ns / 1ps

module i2c_master_transaction_sequencer_tb;
  import i2cs_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    req_t        req;
    logic [7:0]  dev_addr;
    logic [15:0] prefix_count;
    logic [15:0] write_count;
    logic [15:0] read_count;
    logic [7:0]  write_byte;
    logic [7:0]  engine_status;
    logic [7:0]  engine_rx_byte;
  } beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_req_type;
  logic [7:0]  in_dev_addr;
  logic [15:0] in_prefix_count;
  logic [15:0] in_write_count;
  logic [15:0] in_read_count;
  logic [7:0]  in_write_byte;
  logic [7:0]  in_engine_status;
  logic [7:0]  in_engine_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_engine_cmd;
  logic [7:0]  out_engine_tx_byte;
  logic        out_need_write_byte;
  logic        out_rx_valid;
  logic [7:0]  out_rx_byte;
  logic        out_done_res;
  logic [7:0]  out_done_status;

  // Model of the sequencer state.
  phase_t                 txn_phase     = PH_IDLE;
  logic [COUNT_WIDTH:0]   bytes_to_send = '0;
  logic [COUNT_WIDTH-1:0] bytes_to_read = '0;
  logic [7:0]             txn_addr      = '0;
  logic                   txn_has_write = 1'b0;

  seq_result_t pending_engine_results[$];
  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int beats_sent   = 0;
  int mismatches   = 0;
  int quiet_cycles = 0;

  i2c_master_transaction_sequencer u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_dev_addr         (in_dev_addr),
    .in_prefix_count     (in_prefix_count),
    .in_write_count      (in_write_count),
    .in_read_count       (in_read_count),
    .in_write_byte       (in_write_byte),
    .in_engine_status    (in_engine_status),
    .in_engine_rx_byte   (in_engine_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_engine_cmd      (out_engine_cmd),
    .out_engine_tx_byte  (out_engine_tx_byte),
    .out_need_write_byte (out_need_write_byte),
    .out_rx_valid        (out_rx_valid),
    .out_rx_byte         (out_rx_byte),
    .out_done_res        (out_done_res),
    .out_done_status     (out_done_status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void end_txn(inout seq_result_t r, input logic [7:0] status,
                                  input logic with_stop);
    if (with_stop) r.engine_cmd = CMD_STOP;
    r.done_res    = 1'b1;
    r.done_status = status;
    txn_phase     = PH_IDLE;
  endfunction

  // Advances the model by one accepted beat; returns 1 when the beat causes a result.
  function automatic bit step_txn_model(input beat_t b, output seq_result_t r);
    logic [7:0] st;
    logic [7:0] ack_code;
    logic [7:0] nak_code;
    r  = '0;
    st = b.engine_status & ST_MASK;
    case (b.req)
      REQ_TXN: begin
        if (txn_phase != PH_IDLE) return 1'b0;
        txn_addr      = b.dev_addr;
        bytes_to_send = {1'b0, b.prefix_count} + {1'b0, b.write_count};
        bytes_to_read = b.read_count;
        txn_has_write = (bytes_to_send != '0);
        if (bytes_to_send != '0) begin
          r.engine_cmd = CMD_START;
          txn_phase    = PH_WSTART;
        end else if (bytes_to_read != '0) begin
          r.engine_cmd = CMD_START;
          txn_phase    = PH_RSTART;
        end else begin
          end_txn(r, 8'h00, 1'b0);
        end
        return 1'b1;
      end
      REQ_WBYTE: begin
        if (txn_phase != PH_WFETCH) return 1'b0;
        r.engine_cmd     = CMD_SEND;
        r.engine_tx_byte = b.write_byte;
        if (bytes_to_send != '0) bytes_to_send = bytes_to_send - WL_ONE;
        txn_phase = PH_WDATA;
        return 1'b1;
      end
      REQ_EVENT: ;
      default: return 1'b0;
    endcase

    case (txn_phase)
      PH_WSTART: begin
        if (st != ST_START) begin
          end_txn(r, st, 1'b0);
        end else begin
          r.engine_cmd     = CMD_SEND;
          r.engine_tx_byte = txn_addr & ADDR_WMASK;
          txn_phase        = PH_WADDR;
        end
      end
      PH_WADDR, PH_WDATA: begin
        ack_code = (txn_phase == PH_WADDR) ? ST_WADDR_ACK : ST_WDATA_ACK;
        nak_code = (txn_phase == PH_WADDR) ? ST_WADDR_NAK : ST_WDATA_NAK;
        if (st != ack_code) begin
          end_txn(r, st, st == nak_code);
        end else if (bytes_to_send != '0) begin
          r.need_write_byte = 1'b1;
          txn_phase         = PH_WFETCH;
        end else if (bytes_to_read != '0) begin
          r.engine_cmd = CMD_START;
          txn_phase    = PH_RSTART;
        end else begin
          end_txn(r, 8'h00, 1'b1);
        end
      end
      PH_RSTART: begin
        if (st != (txn_has_write ? ST_REP_START : ST_START)) begin
          end_txn(r, st, 1'b0);
        end else begin
          r.engine_cmd     = CMD_SEND;
          r.engine_tx_byte = txn_addr | 8'h01;
          txn_phase        = PH_RADDR;
        end
      end
      PH_RADDR: begin
        if (st != ST_RADDR_ACK) begin
          end_txn(r, st, st == ST_RADDR_NAK);
        end else begin
          r.engine_cmd = (bytes_to_read > RL_ONE) ? CMD_RACK : CMD_RNACK;
          txn_phase    = PH_RDATA;
        end
      end
      PH_RDATA: begin
        if (st != ((bytes_to_read > RL_ONE) ? ST_RDATA_ACK : ST_RDATA_NAK)) begin
          end_txn(r, st, 1'b0);
        end else begin
          r.rx_valid = 1'b1;
          r.rx_byte  = b.engine_rx_byte;
          if (bytes_to_read != '0) bytes_to_read = bytes_to_read - RL_ONE;
          if (bytes_to_read != '0) r.engine_cmd = (bytes_to_read > RL_ONE) ? CMD_RACK : CMD_RNACK;
          else end_txn(r, 8'h00, 1'b1);
        end
      end
      default: return 1'b0;  // Idle or waiting for a write byte.
    endcase
    return 1'b1;
  endfunction

  function automatic beat_t random_beat();
    beat_t b;
    b.req            = req_t'($urandom_range(0, 3));
    b.dev_addr       = 8'($urandom);
    b.prefix_count   = 16'($urandom);
    b.write_count    = 16'($urandom);
    b.read_count     = 16'($urandom);
    b.write_byte     = 8'($urandom);
    b.engine_status  = 8'($urandom);
    b.engine_rx_byte = 8'($urandom);
    return b;
  endfunction

  // Builds the beat the host would send next in the current phase. A fault replaces
  // the expected status with the phase's NAK code or with a random status.
  function automatic beat_t protocol_beat(input bit fault, input int nak_pct);
    beat_t      b;
    logic [7:0] good;
    logic [7:0] nak;
    bit         has_nak;
    b       = random_beat();
    b.req   = REQ_EVENT;
    has_nak = 1'b0;
    nak     = 8'h00;
    case (txn_phase)
      PH_WSTART: good = ST_START;
      PH_WADDR: begin
        good    = ST_WADDR_ACK;
        nak     = ST_WADDR_NAK;
        has_nak = 1'b1;
      end
      PH_WFETCH: begin
        b.req = REQ_WBYTE;
        return b;
      end
      PH_WDATA: begin
        good    = ST_WDATA_ACK;
        nak     = ST_WDATA_NAK;
        has_nak = 1'b1;
      end
      PH_RSTART: good = txn_has_write ? ST_REP_START : ST_START;
      PH_RADDR: begin
        good    = ST_RADDR_ACK;
        nak     = ST_RADDR_NAK;
        has_nak = 1'b1;
      end
      default: good = (bytes_to_read > RL_ONE) ? ST_RDATA_ACK : ST_RDATA_NAK;
    endcase
    if (!fault) b.engine_status = good | (b.engine_status & ~ST_MASK);
    else if (has_nak && $urandom_range(0, 99) < nak_pct)
      b.engine_status = nak | (b.engine_status & ~ST_MASK);
    return b;
  endfunction

  // A beat that the block must swallow in the current, busy phase.
  function automatic beat_t off_phase_beat();
    beat_t b;
    b = random_beat();
    case ($urandom_range(0, 2))
      0: b.req = REQ_TXN;
      1: b.req = (txn_phase == PH_WFETCH) ? REQ_EVENT : REQ_WBYTE;
      default: b.req = REQ_NONE;
    endcase
    return b;
  endfunction

  // Valid is only lowered when the sender takes a gap, so back-to-back beats
  // never see a low and a high assignment in the same step.
  task automatic send_beat(input beat_t b);
    seq_result_t r;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_req_type       <= b.req;
    in_dev_addr       <= b.dev_addr;
    in_prefix_count   <= b.prefix_count;
    in_write_count    <= b.write_count;
    in_read_count     <= b.read_count;
    in_write_byte     <= b.write_byte;
    in_engine_status  <= b.engine_status;
    in_engine_rx_byte <= b.engine_rx_byte;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    if (step_txn_model(b, r)) pending_engine_results.push_back(r);
  endtask

  // Runs one transaction to its end. fault_at names a phase whose event gets its
  // NAK code; abort_after forces faults once that many beats have gone by.
  task automatic run_txn(input logic [7:0] addr, input logic [15:0] n_prefix,
                         input logic [15:0] n_write, input logic [15:0] n_read,
                         input phase_t fault_at, input int fault_pct,
                         input int abort_after, input int noise_pct);
    beat_t b;
    int    steps;
    bit    fault;
    int    nak_pct;
    b              = random_beat();
    b.req          = REQ_TXN;
    b.dev_addr     = addr;
    b.prefix_count = n_prefix;
    b.write_count  = n_write;
    b.read_count   = n_read;
    send_beat(b);
    steps = 0;
    while (txn_phase != PH_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct) send_beat(off_phase_beat());
      steps++;
      fault   = (txn_phase == fault_at);
      nak_pct = fault ? 100 : 50;
      if ($urandom_range(0, 99) < fault_pct) fault = 1'b1;
      if (abort_after > 0 && steps > abort_after) fault = 1'b1;
      send_beat(protocol_beat(fault, nak_pct));
    end
  endtask

  task automatic test_clean_transactions();
    run_txn(8'hff, 16'h0000, 16'h0000, 16'h0000, PH_IDLE, 0, 0, 0);
    run_txn(8'h00, 16'h0000, 16'h0001, 16'h0001, PH_IDLE, 0, 0, 0);
  endtask

  task automatic test_nak_stops();
    run_txn(8'ha5, 16'hffff, 16'hffff, 16'hffff, PH_WADDR, 0, 0, 0);
    run_txn(8'h3c, 16'h0001, 16'h0000, 16'h0000, PH_WDATA, 0, 0, 0);
    run_txn(8'h5a, 16'h0000, 16'h0000, 16'h0001, PH_RADDR, 0, 0, 0);
  endtask

  task automatic test_idle_wrong_phase();
    beat_t b;
    b = random_beat();
    b.req = REQ_EVENT;
    send_beat(b);
    b = random_beat();
    b.req = REQ_WBYTE;
    send_beat(b);
    b = random_beat();
    b.req = REQ_NONE;
    send_beat(b);
  endtask

  // Mostly short transactions; now and then full-width counts that get cut off
  // by a bad status after a few beats.
  task automatic test_random_traffic(input int n_beats, input int in_pct, input int out_pct);
    int          stop_at;
    int          pick;
    int          abort_after;
    logic [15:0] n_prefix;
    logic [15:0] n_write;
    logic [15:0] n_read;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    stop_at      = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      pick        = $urandom_range(0, 99);
      abort_after = 0;
      if (pick < 85) begin
        n_prefix = 16'($urandom_range(0, 2));
        n_write  = 16'($urandom_range(0, 3));
        n_read   = 16'($urandom_range(0, 4));
      end else begin
        n_prefix    = $urandom_range(0, 1) ? 16'($urandom) : 16'h0000;
        n_write     = $urandom_range(0, 1) ? 16'($urandom) : 16'h0000;
        n_read      = $urandom_range(0, 1) ? 16'($urandom) : 16'h0000;
        abort_after = $urandom_range(1, 6);
      end
      run_txn(8'($urandom), n_prefix, n_write, n_read, PH_IDLE, 6, abort_after, 10);
    end
  endtask

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s expected 0x%0h got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    seq_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_engine_results.size() == 0) begin
        $error("result beat arrived with no prediction pending");
        mismatches++;
      end else begin
        want = pending_engine_results.pop_front();
        check_field("engine_cmd", 8'(want.engine_cmd), 8'(out_engine_cmd));
        check_field("engine_tx_byte", want.engine_tx_byte, out_engine_tx_byte);
        check_field("need_write_byte", 8'(want.need_write_byte), 8'(out_need_write_byte));
        check_field("rx_valid", 8'(want.rx_valid), 8'(out_rx_valid));
        check_field("rx_byte", want.rx_byte, out_rx_byte);
        check_field("done_res", 8'(want.done_res), 8'(out_done_res));
        check_field("done_status", want.done_status, out_done_status);
      end
    end
  end

  // Ends the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_req_type       <= REQ_NONE;
    in_dev_addr       <= '0;
    in_prefix_count   <= '0;
    in_write_count    <= '0;
    in_read_count     <= '0;
    in_write_byte     <= '0;
    in_engine_status  <= '0;
    in_engine_rx_byte <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    in_idle_pct  = 12;
    out_idle_pct = 83;
    test_clean_transactions();
    test_nak_stops();
    test_idle_wrong_phase();
    test_random_traffic(270, 12, 83);
    test_random_traffic(270, 83, 12);
    test_random_traffic(270, 0, 0);
    in_valid <= 1'b0;

    while (pending_engine_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/i2cs_pkg.sv
sv/i2cs_step.sv
sv/i2c_master_transaction_sequencer.sv
tb/i2c_master_transaction_sequencer_tb.sv
